// ----- design/bitmap_page_allocator_unit_macros.svh -----
// assertion macros for the checker in bpa_checker.sv
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BPA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap page allocator check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap page allocator check failed");

`endif

// ----- design/bpa_pkg.sv -----
package bpa_pkg;

  localparam int MAP_WORDS   = 128;
  localparam int WORD_BITS   = 32;
  localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
  localparam int WADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int PAGE_W      = 12;
  localparam int COUNT_W     = 13;
  localparam int STATUS_W    = 2;

  // a mixed word is scanned a chunk per cycle
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_LOG   = $clog2(CHUNK_BITS);
  localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;
  localparam int CHUNK_W     = $clog2(CHUNKS);

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;

  // field positions in the packed buses
  localparam int IN_COUNT_LSB   = 0;
  localparam int IN_START_LSB   = COUNT_W;
  localparam int IN_USED_W      = COUNT_W + PAGE_W;
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_START_LSB  = STATUS_W;
  localparam int OUT_FREE_LSB   = STATUS_W + PAGE_W;
  localparam int OUT_USED_W     = STATUS_W + PAGE_W + COUNT_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_EVAL,
    S_MARK_RD,
    S_MARK_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    srch_init;
    logic    rd_en;
    logic    rd_next;
    logic    srch_step;
    logic    mark_init;
    logic    mark_next;
    logic    wr_en;
    logic    status_we;
    status_t status;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_release;
    logic hit;
    logic word_done;
    logic last_word;
    logic mark_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- design/bpa_datapath.sv -----
module bpa_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [bpa_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [bpa_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  bpa_pkg::dp_cmd_t                   cmd,
  output bpa_pkg::dp_sts_t                   sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bpa_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int WB  = bpa_pkg::WORD_BITS;
  localparam int AW  = bpa_pkg::WADDR_W;
  localparam int BW  = bpa_pkg::BIT_W;
  localparam int PW  = bpa_pkg::PAGE_W;
  localparam int CW  = bpa_pkg::COUNT_W;

  // request
  bpa_pkg::op_t               op_r;
  logic [CW-1:0]              count_r;
  logic [PW-1:0]              sp_r;

  // walk state
  logic [AW-1:0]              word_r;
  logic [bpa_pkg::CHUNK_W-1:0] chunk_r;
  logic [CW-1:0]              run_r;
  logic [PW-1:0]              first_r;
  logic [PW-1:0]              start_r;
  logic [PW-1:0]              mfirst_r;
  logic [PW-1:0]              mlast_r;
  bpa_pkg::status_t           status_r;
  logic [CW-1:0]              free_r;

  // result register
  logic                       out_valid_r;
  bpa_pkg::status_t           out_status_r;
  logic [PW-1:0]              out_start_r;
  logic [CW-1:0]              out_free_r;

  // page map, invalid entries read as all used
  logic [WB-1:0]              mem [bpa_pkg::MAP_WORDS];
  logic [bpa_pkg::MAP_WORDS-1:0] vld_r;
  logic [WB-1:0]              rdata_r;

  logic [AW-1:0]              rd_addr_c;
  logic [WB-1:0]              wdata_c;
  logic [WB-1:0]              mask_c;
  logic [BW-1:0]              lo_c;
  logic [BW-1:0]              hi_c;
  logic                       bad_c;
  logic [CW:0]                rel_end_c;
  logic [CW-1:0]              run_c;
  logic [PW-1:0]              first_c;
  logic                       hit_c;
  logic [PW-1:0]              hit_start_c;
  logic                       word_done_c;
  logic [PW-1:0]              mbase_c;
  logic [CW-1:0]              mend_c;
  logic [CW-1:0]              fc_alloc_c;
  logic [CW:0]                fc_sum_c;
  logic [CW-1:0]              fc_rel_c;
  logic [CW-1:0]              fc_new_c;

  // request checks
  always_comb begin
    rel_end_c = {1'b0, CW'(sp_r)} + {1'b0, count_r};
    if (op_r == bpa_pkg::OP_RELEASE) begin
      bad_c = (count_r == '0) || (rel_end_c > (CW+1)'(bpa_pkg::TOTAL_PAGES));
    end else begin
      bad_c = (count_r == '0) || (count_r > CW'(bpa_pkg::TOTAL_PAGES));
    end
  end

  // first-fit step over the word in rdata_r
  always_comb begin
    logic [BW-1:0] bidx;
    bidx        = '0;
    run_c       = run_r;
    first_c     = first_r;
    hit_c       = 1'b0;
    hit_start_c = first_r;
    if (rdata_r == '1) begin
      run_c = '0;
    end else if (rdata_r == '0) begin
      if (run_r == '0) begin
        first_c = {word_r, BW'(0)};
      end
      run_c = run_r + CW'(WB);
      if (run_c >= count_r) begin
        hit_c       = 1'b1;
        hit_start_c = first_c;
      end
    end else begin
      for (int k = 0; k < bpa_pkg::CHUNK_BITS; k++) begin
        bidx = {chunk_r, bpa_pkg::CHUNK_LOG'(k)};
        if (!hit_c) begin
          if (rdata_r[bidx]) begin
            run_c = '0;
          end else begin
            if (run_c == '0) begin
              first_c = {word_r, bidx};
            end
            run_c = run_c + 1'b1;
            if (run_c >= count_r) begin
              hit_c       = 1'b1;
              hit_start_c = first_c;
            end
          end
        end
      end
    end
    word_done_c = (rdata_r == '1) || (rdata_r == '0) ||
                  (chunk_r == bpa_pkg::CHUNK_W'(bpa_pkg::CHUNKS - 1));
  end

  // mark pass: bit range within the current word
  always_comb begin
    mbase_c = (op_r == bpa_pkg::OP_RELEASE) ? sp_r : hit_start_c;
    mend_c  = CW'(mbase_c) + count_r - 1'b1;
    lo_c    = (word_r == mfirst_r[PW-1:BW]) ? mfirst_r[BW-1:0] : '0;
    hi_c    = (word_r == mlast_r[PW-1:BW])  ? mlast_r[BW-1:0]  : '1;
    mask_c  = ({WB{1'b1}} << lo_c) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_c));
    wdata_c = (op_r == bpa_pkg::OP_RELEASE) ? (rdata_r & ~mask_c) : (rdata_r | mask_c);
  end

  assign rd_addr_c = cmd.rd_next ? AW'(word_r + 1'b1) : word_r;

  // free count after the request
  always_comb begin
    fc_alloc_c = (free_r >= count_r) ? (free_r - count_r) : '0;
    fc_sum_c   = {1'b0, free_r} + {1'b0, count_r};
    fc_rel_c   = (fc_sum_c > (CW+1)'(bpa_pkg::TOTAL_PAGES)) ?
                 CW'(bpa_pkg::TOTAL_PAGES) : fc_sum_c[CW-1:0];
    if (status_r != bpa_pkg::ST_OK) begin
      fc_new_c = free_r;
    end else if (op_r == bpa_pkg::OP_RELEASE) begin
      fc_new_c = fc_rel_c;
    end else begin
      fc_new_c = fc_alloc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[word_r] <= wdata_c;
    end
    if (cmd.rd_en) begin
      rdata_r <= vld_r[rd_addr_c] ? mem[rd_addr_c] : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[word_r] <= 1'b1;
      end
      if (cmd.finish) begin
        free_r      <= fc_new_c;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r    <= bpa_pkg::op_t'(in_tuser[0]);
      count_r <= in_tdata[bpa_pkg::IN_COUNT_LSB +: CW];
      sp_r    <= in_tdata[bpa_pkg::IN_START_LSB +: PW];
    end
    if (cmd.srch_init) begin
      word_r  <= '0;
      chunk_r <= '0;
      run_r   <= '0;
      first_r <= '0;
    end
    if (cmd.srch_step) begin
      run_r   <= run_c;
      first_r <= first_c;
      if (word_done_c) begin
        chunk_r <= '0;
        word_r  <= AW'(word_r + 1'b1);
      end else begin
        chunk_r <= bpa_pkg::CHUNK_W'(chunk_r + 1'b1);
      end
    end
    if (cmd.mark_next) begin
      word_r <= AW'(word_r + 1'b1);
    end
    // mark setup overrides the search advance in the hit cycle
    if (cmd.mark_init) begin
      start_r  <= hit_start_c;
      mfirst_r <= mbase_c;
      mlast_r  <= mend_c[PW-1:0];
      word_r   <= mbase_c[PW-1:BW];
    end
    if (cmd.status_we) begin
      status_r <= cmd.status;
    end
    if (cmd.finish) begin
      out_status_r <= status_r;
      out_start_r  <= (status_r == bpa_pkg::ST_OK && op_r == bpa_pkg::OP_ALLOC) ?
                      start_r : '0;
      out_free_r   <= fc_new_c;
    end
  end

  always_comb begin
    sts.bad        = bad_c;
    sts.is_release = (op_r == bpa_pkg::OP_RELEASE);
    sts.hit        = hit_c;
    sts.word_done  = word_done_c;
    sts.last_word  = (word_r == AW'(bpa_pkg::MAP_WORDS - 1));
    sts.mark_last  = (word_r == mlast_r[PW-1:BW]);
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bpa_pkg::OUT_TDATA_W - bpa_pkg::OUT_USED_W){1'b0}},
                       out_free_r, out_start_r, out_status_r};

endmodule

// ----- design/bpa_controller.sv -----
module bpa_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  bpa_pkg::dp_sts_t sts,
  output bpa_pkg::dp_cmd_t cmd
);

  bpa_pkg::state_t state_r;
  bpa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.status = bpa_pkg::ST_OK;
    unique case (state_r)
      bpa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = bpa_pkg::S_CHECK;
        end
      end
      bpa_pkg::S_CHECK: begin
        if (sts.bad) begin
          cmd.status_we = 1'b1;
          cmd.status    = bpa_pkg::ST_BAD;
          state_nxt     = bpa_pkg::S_FINISH;
        end else if (sts.is_release) begin
          cmd.mark_init = 1'b1;
          cmd.status_we = 1'b1;
          cmd.status    = bpa_pkg::ST_OK;
          state_nxt     = bpa_pkg::S_MARK_RD;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = bpa_pkg::S_SRCH_RD;
        end
      end
      bpa_pkg::S_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = bpa_pkg::S_SRCH_EVAL;
      end
      bpa_pkg::S_SRCH_EVAL: begin
        cmd.srch_step = 1'b1;
        if (sts.hit) begin
          cmd.mark_init = 1'b1;
          cmd.status_we = 1'b1;
          cmd.status    = bpa_pkg::ST_OK;
          state_nxt     = bpa_pkg::S_MARK_RD;
        end else if (sts.word_done) begin
          if (sts.last_word) begin
            cmd.status_we = 1'b1;
            cmd.status    = bpa_pkg::ST_NO_RUN;
            state_nxt     = bpa_pkg::S_FINISH;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      bpa_pkg::S_MARK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = bpa_pkg::S_MARK_WR;
      end
      bpa_pkg::S_MARK_WR: begin
        cmd.wr_en = 1'b1;
        if (sts.mark_last) begin
          state_nxt = bpa_pkg::S_FINISH;
        end else begin
          cmd.mark_next = 1'b1;
          state_nxt     = bpa_pkg::S_MARK_RD;
        end
      end
      bpa_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bitmap_page_allocator_unit.sv -----
// first-fit page allocator over a bitmap of 4096 pages (128 words of 32 bits, 1 = used);
// after reset every page is used and the free count is 0, so pages must be released
// before they can be allocated. each request is one transfer on the in_ side and gives
// exactly one transfer on the out_ side. requests are handled one at a time: accept,
// a check state, then for an allocate a read of the first word and a search that steps
// over a wholly used or wholly free bitmap word whole and over a mixed word in chunks
// (8 bits a cycle), then a read and a write per bitmap word touched by the run, then
// a load of the result register. a bad request skips the search and the mark pass, and a
// release skips the search. the page map is read and written in separate states, and a
// mixed word is scanned a chunk at a time. a new request is taken while an earlier
// result still waits on out_tready. no clearing pass is needed after reset.
module bitmap_page_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [12:0] page_count, [24:13] start_page, rest zero
  input  logic [bpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation (0 allocate, 1 release)
  input  logic [bpa_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [13:2] run_start, [26:14] free_pages, rest zero
  output logic [bpa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // command and status between controller and datapath
  bpa_pkg::dp_cmd_t cmd;
  bpa_pkg::dp_sts_t sts;

  // sequencer: check, search walk, mark pass, result load
  bpa_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // page map, scan logic, free count and result register
  bpa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- design/bpa_checker.sv -----
`include "bitmap_page_allocator_unit_macros.svh"

module bpa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bpa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [bpa_pkg::STATUS_W-1:0] status;
  logic [bpa_pkg::PAGE_W-1:0]   run_start;
  logic [bpa_pkg::COUNT_W-1:0]  free_pages;
  logic                         status_known;

  assign status     = out_tdata[bpa_pkg::OUT_STATUS_LSB +: bpa_pkg::STATUS_W];
  assign run_start  = out_tdata[bpa_pkg::OUT_START_LSB +: bpa_pkg::PAGE_W];
  assign free_pages = out_tdata[bpa_pkg::OUT_FREE_LSB +: bpa_pkg::COUNT_W];

  assign status_known = (status == bpa_pkg::ST_OK) || (status == bpa_pkg::ST_NO_RUN) ||
                        (status == bpa_pkg::ST_BAD);

  // a stalled result holds
  `BPA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // status is one of the three defined codes
  `BPA_ASSERT_IMP(a_status_code, out_tvalid, status_known)

  // run start is zero unless the request succeeded
  `BPA_ASSERT_IMP(a_start_zero, out_tvalid && status != bpa_pkg::ST_OK, run_start == '0)

  // free count never exceeds the page total
  `BPA_ASSERT_IMP(a_free_bound, out_tvalid, free_pages <= bpa_pkg::COUNT_W'(bpa_pkg::TOTAL_PAGES))

  // one request at a time: the request side closes right after a transfer
  `BPA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);

// ----- tb/page_alloc_checker.sv -----
module page_alloc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [12:0] page_count, [24:13] start_page
  input  logic [bpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic [bpa_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [13:2] run_start, [26:14] free_pages
  input  logic [bpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              pending,
  output int                              n_alloc_ok,
  output int                              n_no_run,
  output int                              n_release,
  output int                              n_bad
);
  import bpa_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [PAGE_W-1:0]    run_start;
    logic [COUNT_W-1:0]   free_pages;
  } alloc_reply_t;

  // 1 = page used
  bit [TOTAL_PAGES-1:0] used_map;
  int unsigned          free_total;
  alloc_reply_t         replies_due[$];
  int                   n_replies;

  // applies one request to the shadow map and returns the reply it should give
  function automatic alloc_reply_t serve_request(op_t op, int unsigned cnt, int unsigned sp);
    alloc_reply_t r;
    int unsigned  run;
    int unsigned  head;
    bit           found;
    r.status    = ST_OK;
    r.run_start = '0;
    run         = 0;
    head        = 0;
    found       = 1'b0;
    if (op == OP_ALLOC) begin
      if (cnt == 0 || cnt > TOTAL_PAGES) begin
        r.status = ST_BAD;
      end else begin
        // plain first fit over the pages, lowest start wins
        for (int p = 0; p < TOTAL_PAGES && !found; p++) begin
          if (used_map[p]) begin
            run = 0;
          end else begin
            if (run == 0) head = p;
            run++;
            if (run >= cnt) found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NO_RUN;
        end else begin
          for (int i = 0; i < cnt; i++) used_map[head + i] = 1'b1;
          free_total  = (free_total >= cnt) ? free_total - cnt : 0;
          r.run_start = head[PAGE_W-1:0];
        end
      end
    end else begin
      if (cnt == 0 || sp + cnt > TOTAL_PAGES) begin
        r.status = ST_BAD;
      end else begin
        for (int i = 0; i < cnt; i++) used_map[sp + i] = 1'b0;
        // count rises even for pages already free, capped at the page total
        free_total = free_total + cnt;
        if (free_total > TOTAL_PAGES) free_total = TOTAL_PAGES;
      end
    end
    r.free_pages = free_total[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_reply_t got;
    op_t          op;
    if (!rst_n) begin
      used_map   = '1;
      free_total = 0;
      replies_due.delete();
      n_replies  = 0;
      mismatches = 0;
      n_alloc_ok = 0;
      n_no_run   = 0;
      n_release  = 0;
      n_bad      = 0;
    end else begin
      // result transfer first, so it only ever matches an earlier request
      if (out_tvalid && out_tready) begin
        got.status     = status_t'(out_tdata[OUT_STATUS_LSB +: STATUS_W]);
        got.run_start  = out_tdata[OUT_START_LSB +: PAGE_W];
        got.free_pages = out_tdata[OUT_FREE_LSB +: COUNT_W];
        n_replies++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply %0d: no request waiting, got status %0d run_start %0d free %0d",
                     n_replies, got.status, got.run_start, got.free_pages);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.run_start !== want.run_start ||
              got.free_pages !== want.free_pages) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply %0d: status %0d/%0d run_start %0d/%0d free %0d/%0d (exp/got)",
                       n_replies, want.status, got.status, want.run_start, got.run_start,
                       want.free_pages, got.free_pages);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        op   = op_t'(in_tuser[0]);
        want = serve_request(op, 32'(in_tdata[IN_COUNT_LSB +: COUNT_W]),
                             32'(in_tdata[IN_START_LSB +: PAGE_W]));
        replies_due.push_back(want);
        if (want.status == ST_BAD)      n_bad++;
        else if (op == OP_RELEASE)      n_release++;
        else if (want.status == ST_OK)  n_alloc_ok++;
        else                            n_no_run++;
      end
    end
    pending = replies_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import bpa_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int n_alloc_ok;
  int n_no_run;
  int n_release;
  int n_bad;

  // stimulus knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down in the receiver process
  int hold_cycles    = 0;
  int n_sent         = 0;

  always #1 clk = ~clk;

  bitmap_page_allocator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  page_alloc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .n_alloc_ok (n_alloc_ok),
    .n_no_run   (n_no_run),
    .n_release  (n_release),
    .n_bad      (n_bad)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one request transfer; returns at the falling edge after the handshake
  task automatic send_request(op_t op, logic [COUNT_W-1:0] cnt, logic [PAGE_W-1:0] sp);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-IN_USED_W){1'b0}}, sp, cnt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // mostly small well-formed allocate/release traffic, some large runs,
  // some malformed requests and some raw noise
  task automatic random_request();
    int unsigned r;
    int unsigned cnt;
    int unsigned sp;
    op_t         op;
    r  = $urandom_range(99);
    sp = $urandom_range(TOTAL_PAGES-1, 0);
    if (r < 45) begin
      op = OP_RELEASE;
      if ($urandom_range(49) == 0) begin
        // free the whole map to undo fragmentation
        cnt = TOTAL_PAGES;
      end else if ($urandom_range(9) == 0) begin
        cnt = $urandom_range(TOTAL_PAGES, 1);
      end else begin
        cnt = $urandom_range(64, 1);
      end
      sp = $urandom_range(TOTAL_PAGES - cnt, 0);
    end else if (r < 92) begin
      op  = OP_ALLOC;
      cnt = ($urandom_range(9) == 0) ? $urandom_range(TOTAL_PAGES, 1) : $urandom_range(48, 1);
    end else if (r < 96) begin
      case ($urandom_range(2))
        0: begin
          op  = op_t'($urandom_range(1, 0));
          cnt = 0;
        end
        1: begin
          op  = OP_ALLOC;
          cnt = $urandom_range(8191, TOTAL_PAGES + 1);
        end
        default: begin
          // release running past the last page
          op  = OP_RELEASE;
          cnt = $urandom_range(8191, TOTAL_PAGES + 1 - sp);
        end
      endcase
    end else begin
      op  = op_t'($urandom_range(1, 0));
      cnt = $urandom_range(8191, 0);
    end
    send_request(op, COUNT_W'(cnt), PAGE_W'(sp));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int items);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (items) random_request();
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // map starts fully used with a free count of zero
    send_request(OP_ALLOC,   1,    0);      // nothing free yet
    send_request(OP_ALLOC,   0,    0);      // zero count
    send_request(OP_RELEASE, 0,    5);      // zero count
    send_request(OP_ALLOC,   4097, 0);      // larger than the map
    send_request(OP_ALLOC,   8191, 4095);   // count all ones
    send_request(OP_RELEASE, 2,    4095);   // past the end
    send_request(OP_RELEASE, 8191, 4095);   // past the end, all ones
    send_request(OP_RELEASE, 1,    4095);   // last page
    send_request(OP_ALLOC,   1,    0);      // gets the last page
    send_request(OP_RELEASE, 4096, 0);      // whole map, count reaches the total
    send_request(OP_RELEASE, 4096, 0);      // already free, stays at total
    send_request(OP_ALLOC,   4096, 0);      // whole map
    send_request(OP_ALLOC,   1,    0);      // map full again
    send_request(OP_RELEASE, 4,    30);     // run across a word boundary
    send_request(OP_ALLOC,   4,    0);
    send_request(OP_RELEASE, 4,    60);     // tail of one word
    send_request(OP_RELEASE, 4,    96);     // head of a word after a full one
    send_request(OP_ALLOC,   5,    0);      // partial run meets a full word
    send_request(OP_ALLOC,   4,    0);
    send_request(OP_RELEASE, 8,    100);
    send_request(OP_RELEASE, 8,    100);    // releasing free pages again
    send_request(OP_ALLOC,   3,    0);
    send_request(OP_ALLOC,   9,    0);
    send_request(OP_RELEASE, 2048, 2048);
    send_request(OP_ALLOC,   2048, 0);
    in_tvalid <= 1'b0;
    wait_drained();

    run_phase(0,  0,  280);
    run_phase(69, 0,  280);
    run_phase(0,  69, 280);
    run_phase(13, 13, 280);

    // receiver holds off while requests keep coming, block backs up
    hold_cycles = 400;
    run_phase(0, 0, 12);

    // room for any stray result after the last expected one
    repeat (800) @(negedge clk);

    $display("%0d requests over no-idle, sender-gap, receiver-stall, mixed and hold-off phases",
             n_sent);
    $display("%0d runs placed, %0d with no run, %0d releases, %0d bad requests",
             n_alloc_ok, n_no_run, n_release, n_bad);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
